// ===== design/mcaf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcaf_pkg
// Shared types and constants of the motor current abs IIR filter: word
// layouts, controller states, command and status bundles, filter coefficients.
// ----------------------------------------------------------------------------
package mcaf_pkg;

    // Block configuration
    localparam int NUM_CHANNELS   = 4;
    localparam int SAMPLE_BITS    = 16;
    localparam int NUM_SCALE_REGS = 4;

    // Field and port widths
    localparam int CH_W      = 2;
    localparam int RAW_W     = 16;
    localparam int SCALE_W   = 16;
    localparam int MA_W      = 17;
    localparam int UA_W      = 26;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Datapath widths
    localparam int MAG_W  = 16;
    localparam int SUM_W  = 17;
    localparam int FILT_W = 34;
    localparam int HALF_W = 17;
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 50;

    // Register index of the first scale register
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_CH0 = 3'd0;

    // Constants
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd3198;
    localparam logic [MUL_W-1:0]   COEF_A1_Q16 = 17'd64789;
    localparam logic [MUL_W-1:0]   COEF_A2_Q12 = 17'd23347;
    localparam logic [RAW_W-1:0]   SAMPLE_MASK = RAW_W'((32'd1 << SAMPLE_BITS) - 32'd1);
    localparam logic [4:0]         NUM_CH_V    = 5'(NUM_CHANNELS);

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [RAW_W-1:0] raw_sample;
        logic             positive_dir;
    } mcaf_in_t;

    typedef struct packed {
        logic signed [MA_W-1:0] current_ma;
        logic [UA_W-1:0]        filtered_ua;
    } mcaf_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLO,
        ST_FHI,
        ST_SUM,
        ST_FIN
    } mcaf_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul_flo;
        logic mul_fhi;
        logic mul_sum;
        logic finish;
    } mcaf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_blocked;
    } mcaf_stat_t;

endpackage

// ===== design/mcaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcaf_ctrl
// Sequencer: steps one word through scale, two filter partial products,
// the input term and the final add, and gates the input stall.
// ----------------------------------------------------------------------------
module mcaf_ctrl
    import mcaf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  mcaf_stat_t stat,
    output mcaf_cmd_t  cmd
);

    mcaf_state_t state_reg;
    mcaf_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FLO;
                end
            end
            ST_FLO:
            begin
                cmd.mul_flo = 1'b1;
                state_next  = ST_FHI;
            end
            ST_FHI:
            begin
                cmd.mul_fhi = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.mul_sum = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register can take the result
                if (!stat.out_blocked)
                begin
                    cmd.finish = 1'b1;
                    in_stall   = 1'b0;
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_FLO;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/mcaf_dpath.sv =====
// ----------------------------------------------------------------------------
// mcaf_dpath
// Datapath: scale registers, per-channel reading and filter state, one
// shared 17x17 multiplier, accumulator and the output register.
// ----------------------------------------------------------------------------
module mcaf_dpath
    import mcaf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mcaf_cmd_t            cmd,
    output mcaf_stat_t           stat,
    input  mcaf_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mcaf_out_t            out_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    logic [SCALE_W-1:0] scale_reg [NUM_SCALE_REGS];
    logic [MAG_W-1:0]   pres_mag_reg [NUM_CHANNELS];
    logic [FILT_W-1:0]  filt_reg [NUM_CHANNELS];

    logic [CH_W-1:0]        ch_reg;
    logic                   ch_ok_reg;
    logic                   dir_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic signed [MA_W-1:0] ma_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic                   out_valid_reg;
    mcaf_out_t              out_reg;

    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [MAG_W-1:0]       mag_w;
    logic [FILT_W-1:0]      filt_cur;
    logic [FILT_W-1:0]      term1;
    logic [FILT_W-1:0]      term2;
    logic [FILT_W:0]        fsum;
    logic [FILT_W-1:0]      fsat;
    logic [CFG_IDX_W-1:0]   cfg_rel;

    assign filt_cur = filt_reg[ch_reg];
    assign mag_w    = prod_reg[2*RAW_W-1:RAW_W];

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        priority if (cmd.load)
        begin
            mul_a = {1'b0, in_data.raw_sample & SAMPLE_MASK};
            mul_b = {1'b0, scale_reg[in_data.channel]};
        end
        else if (cmd.mul_flo)
        begin
            mul_a = COEF_A1_Q16;
            mul_b = filt_cur[HALF_W-1:0];
        end
        else if (cmd.mul_fhi)
        begin
            mul_a = COEF_A1_Q16;
            mul_b = filt_cur[FILT_W-1:HALF_W];
        end
        else if (cmd.mul_sum)
        begin
            mul_a = COEF_A2_Q12;
            mul_b = sum_reg;
        end
    end

    // Final add and saturation
    assign term1 = acc_reg[ACC_W-1:ACC_W-FILT_W];
    assign term2 = {6'd0, prod_reg[2*RAW_W-1:4]};
    assign fsum  = {1'b0, term1} + {1'b0, term2};
    assign fsat  = fsum[FILT_W] ? {FILT_W{1'b1}} : fsum[FILT_W-1:0];

    // Multiply and accumulate; hold the product while the last step waits
    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.mul_flo || cmd.mul_fhi || cmd.mul_sum)
        begin
            prod_reg <= {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
        end
        if (cmd.load)
        begin
            ch_reg    <= in_data.channel;
            ch_ok_reg <= ({3'd0, in_data.channel} < NUM_CH_V);
            dir_reg   <= in_data.positive_dir;
        end
        if (cmd.mul_flo)
        begin
            mag_reg <= mag_w;
            ma_reg  <= dir_reg ? $signed({1'b0, mag_w}) : -$signed({1'b0, mag_w});
        end
        if (cmd.mul_fhi)
        begin
            sum_reg <= {1'b0, pres_mag_reg[ch_reg]} + {1'b0, mag_reg};
            acc_reg <= {{(ACC_W-2*RAW_W-1){1'b0}}, prod_reg[2*RAW_W:0]};
        end
        if (cmd.mul_sum)
        begin
            acc_reg <= acc_reg + {prod_reg[2*RAW_W:0], {HALF_W{1'b0}}};
        end
        if (cmd.finish)
        begin
            if (ch_ok_reg)
            begin
                out_reg.current_ma  <= ma_reg;
                out_reg.filtered_ua <= fsat[FILT_W-1:FILT_W-UA_W];
            end
            else
            begin
                out_reg <= '0;
            end
        end
    end

    assign cfg_rel = cfg_index - REG_SCALE_CH0;

    // Update configuration and per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SCALE_REGS; i++)
            begin
                scale_reg[i] <= SCALE_RESET;
            end
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pres_mag_reg[i] <= '0;
                filt_reg[i]     <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_rel < CFG_IDX_W'(NUM_SCALE_REGS)))
            begin
                scale_reg[cfg_rel[1:0]] <= cfg_data;
            end
            if (cmd.mul_fhi && ch_ok_reg)
            begin
                pres_mag_reg[ch_reg] <= mag_reg;
            end
            if (cmd.finish && ch_ok_reg)
            begin
                filt_reg[ch_reg] <= fsat;
            end
            // hold the output word until it is taken
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_blocked = out_valid_reg && out_stall;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;

endmodule

// ===== design/motor_current_abs_iir_filter.sv =====
// ----------------------------------------------------------------------------
// motor_current_abs_iir_filter
// Per-channel current scaling to signed milliamps and first-order low-pass
// of the absolute current in microamps, saturated.
//
//   Channel   Handshake             Payload
//   in        in_valid / in_stall   in_data   (channel, raw_sample, positive_dir)
//   out       out_valid / out_stall out_data  (current_ma, filtered_ua)
//   cfg       cfg_valid / cfg_ready cfg_index, cfg_data (scale_ch0..3)
//
// Per word, the shared 17x17 multiplier runs the scale
// product, two filter partial products and the input term in turn, and the
// last step adds, saturates and loads the output register.
// The next word is taken in that last step, while the previous one finishes.
// A full output register under stall holds the last step until it drains.
// Reset sets the scale registers to 3198 and clears readings and filters.
// ----------------------------------------------------------------------------
module motor_current_abs_iir_filter
    import mcaf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mcaf_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mcaf_out_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    mcaf_cmd_t  cmd;
    mcaf_stat_t stat;

    assign cfg_ready = 1'b1;

    mcaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcaf_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
